/* rtl/idll_pkg.sv */
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types and constants for the indexed doubly linked list core.
// ----------------------------------------------------------------------------
package idll_pkg;

    localparam int ID_W          = 7;
    localparam int DEFAULT_NODES = 64;

    typedef enum logic [1:0] {
        OP_INS_LEFT  = 2'd0,
        OP_INS_RIGHT = 2'd1,
        OP_DELETE    = 2'd2,
        OP_WALK      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_ERROR   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_LINK,
        S_RESULT,
        S_WALK_RD,
        S_WALK_EMIT
    } state_t;

endpackage

/* rtl/idll_ram.sv */
// ----------------------------------------------------------------------------
// idll_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/indexed_doubly_linked_list_core.sv */
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_core
// Ordered list of node ids kept in left and right link RAMs with a head
// pointer; supports insert left/right, delete and a walk from the head.
// ----------------------------------------------------------------------------
// Sequence: insert and delete go through fetch, check, relink and result;
// a rejected insert or ignored delete skips relink and goes to result.
// Flow: one item at a time; a walk emits a node per hop: a read state for
// the registered right link RAM read, then an emit that waits on output.
// Reset: head is node 1, next free id is 2; RAM entries are never cleared,
// ids at or above the next free id are treated as absent and node 1 reads
// as unlinked until its links are first written.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_core
    import idll_pkg::*;
#(
    parameter int NODES = DEFAULT_NODES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [6:0] ref_node, [7] zero
    input  logic [1:0] s_axis_tuser,   // [1:0] operation
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] node_id, [7] zero
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    localparam int ADDR_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int LW     = ID_W + 1;

    localparam logic [ID_W-1:0]  ID_NONE  = '0;
    localparam logic [ID_W-1:0]  ID_ONE   = ID_W'(1);
    localparam logic [ID_W-1:0]  ID_MAX   = ID_W'(NODES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NODES - 1);

    function automatic logic [ADDR_W-1:0] id_addr(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] t;
        t = id - ID_ONE;
        return t[ADDR_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ID_W-1:0]   ref_reg, ref_next;
    logic [ID_W-1:0]   lk_reg, lk_next;
    logic [ID_W-1:0]   rk_reg, rk_next;
    logic [ID_W-1:0]   head_reg, head_next;
    logic [ID_W-1:0]   nfid_reg, nfid_next;
    logic [ID_W-1:0]   cur_reg, cur_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    status_t           res_stat_reg, res_stat_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic              out_last_reg, out_last_next;
    status_t           out_stat_reg, out_stat_next;
    logic              l1_valid_reg, l1_valid_next;
    logic              r1_valid_reg, r1_valid_next;
    logic              lz_reg, lz_next;
    logic              rz_reg, rz_next;

    logic              in_fire;
    logic              out_free;
    logic              walk_last;
    logic [ID_W-1:0]   rd_id;
    logic [LW-1:0]     l_rdata;
    logic [ID_W-1:0]   r_rdata;
    logic [ID_W-1:0]   lk;
    logic [ID_W-1:0]   rk;
    logic              rm;
    logic              present;
    logic              ins_ok;
    logic              is_insert;

    logic              l_we, r_we;
    logic [ID_W-1:0]   l_wid, r_wid;
    logic [LW-1:0]     l_wdata;
    logic [ID_W-1:0]   r_wdata;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_id_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_stat_reg;

    assign lk = lz_reg ? ID_NONE : l_rdata[ID_W-1:0];
    assign rm = lz_reg ? 1'b0 : l_rdata[ID_W];
    assign rk = rz_reg ? ID_NONE : r_rdata;

    assign present   = (ref_reg != ID_NONE) && (ref_reg <= ID_MAX)
                       && (ref_reg < nfid_reg) && !rm;
    assign ins_ok    = present && (nfid_reg <= ID_MAX);
    assign is_insert = (op_reg == OP_INS_LEFT) || (op_reg == OP_INS_RIGHT);
    assign walk_last = (rk == ID_NONE) || (cnt_reg == CNT_LAST);

    assign rd_id = ((state_reg == S_WALK_RD) || (state_reg == S_WALK_EMIT))
                   ? cur_reg : ref_reg;

    idll_ram #(
        .WIDTH (LW),
        .DEPTH (NODES)
    ) u_left_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (id_addr(l_wid)),
        .wdata (l_wdata),
        .raddr (id_addr(rd_id)),
        .rdata (l_rdata)
    );

    idll_ram #(
        .WIDTH (ID_W),
        .DEPTH (NODES)
    ) u_right_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (id_addr(r_wid)),
        .wdata (r_wdata),
        .raddr (id_addr(rd_id)),
        .rdata (r_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (op_t'(s_axis_tuser) == OP_WALK)
                    begin
                        state_next = (head_reg == ID_NONE) ? S_RESULT : S_WALK_RD;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (is_insert)
                begin
                    state_next = ins_ok ? S_LINK : S_RESULT;
                end
                else
                begin
                    state_next = present ? S_LINK : S_RESULT;
                end
            end
            S_LINK:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_EMIT;
            end
            S_WALK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = walk_last ? S_IDLE : S_WALK_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // RAM writes
    always_comb
    begin
        l_we    = 1'b0;
        r_we    = 1'b0;
        l_wid   = nfid_reg;
        r_wid   = nfid_reg;
        l_wdata = '0;
        r_wdata = '0;
        if (state_reg == S_CHECK)
        begin
            unique case (op_reg)
                OP_INS_LEFT:
                begin
                    l_we    = ins_ok;
                    l_wdata = {1'b0, lk};
                    r_we    = ins_ok;
                    r_wdata = ref_reg;
                end
                OP_INS_RIGHT:
                begin
                    l_we    = ins_ok;
                    l_wdata = {1'b0, ref_reg};
                    r_we    = ins_ok;
                    r_wdata = rk;
                end
                OP_DELETE:
                begin
                    l_we    = present;
                    l_wid   = ref_reg;
                    l_wdata = {1'b1, ID_NONE};
                    r_we    = present && (lk != ID_NONE);
                    r_wid   = lk;
                    r_wdata = rk;
                end
                OP_WALK:
                begin
                    l_we = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_LINK)
        begin
            unique case (op_reg)
                OP_INS_LEFT:
                begin
                    l_we    = 1'b1;
                    l_wid   = ref_reg;
                    l_wdata = {1'b0, nfid_reg};
                    r_we    = (lk_reg != ID_NONE);
                    r_wid   = lk_reg;
                    r_wdata = nfid_reg;
                end
                OP_INS_RIGHT:
                begin
                    l_we    = (rk_reg != ID_NONE);
                    l_wid   = rk_reg;
                    l_wdata = {1'b0, nfid_reg};
                    r_we    = 1'b1;
                    r_wid   = ref_reg;
                    r_wdata = nfid_reg;
                end
                OP_DELETE:
                begin
                    l_we    = (rk_reg != ID_NONE);
                    l_wid   = rk_reg;
                    l_wdata = {1'b0, lk_reg};
                    r_we    = 1'b1;
                    r_wid   = ref_reg;
                    r_wdata = ID_NONE;
                end
                OP_WALK:
                begin
                    l_we = 1'b0;
                end
            endcase
        end
    end

    // datapath
    always_comb
    begin
        op_next        = op_reg;
        ref_next       = ref_reg;
        lk_next        = lk_reg;
        rk_next        = rk_reg;
        head_next      = head_reg;
        nfid_next      = nfid_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        res_id_next    = res_id_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;
        out_stat_next  = out_stat_reg;
        l1_valid_next  = l1_valid_reg || (l_we && (l_wid == ID_ONE));
        r1_valid_next  = r1_valid_reg || (r_we && (r_wid == ID_ONE));
        lz_next        = (rd_id == ID_ONE) && !l1_valid_reg;
        rz_next        = (rd_id == ID_ONE) && !r1_valid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next       = op_t'(s_axis_tuser);
                    ref_next      = s_axis_tdata[ID_W-1:0];
                    cur_next      = head_reg;
                    cnt_next      = '0;
                    res_id_next   = ID_NONE;
                    res_stat_next = STAT_DONE;
                end
            end
            S_CHECK:
            begin
                lk_next = lk;
                rk_next = rk;
                if (is_insert && !ins_ok)
                begin
                    res_stat_next = STAT_ERROR;
                end
                else if (!is_insert && !present)
                begin
                    res_stat_next = STAT_IGNORED;
                end
            end
            S_LINK:
            begin
                if (is_insert)
                begin
                    res_id_next = nfid_reg;
                    nfid_next   = nfid_reg + ID_ONE;
                    if ((op_reg == OP_INS_LEFT) && (lk_reg == ID_NONE))
                    begin
                        head_next = nfid_reg;
                    end
                end
                else if (head_reg == ref_reg)
                begin
                    head_next = rk_reg;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_last_next  = 1'b1;
                    out_stat_next  = res_stat_reg;
                end
            end
            S_WALK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = cur_reg;
                    out_last_next  = walk_last;
                    out_stat_next  = STAT_DONE;
                    cur_next       = rk;
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= ID_ONE;
            nfid_reg      <= ID_W'(2);
            out_valid_reg <= 1'b0;
            l1_valid_reg  <= 1'b0;
            r1_valid_reg  <= 1'b0;
            lz_reg        <= 1'b0;
            rz_reg        <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            nfid_reg      <= nfid_next;
            out_valid_reg <= out_valid_next;
            l1_valid_reg  <= l1_valid_next;
            r1_valid_reg  <= r1_valid_next;
            lz_reg        <= lz_next;
            rz_reg        <= rz_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ref_reg      <= ref_next;
        lk_reg       <= lk_next;
        rk_reg       <= rk_next;
        cur_reg      <= cur_next;
        res_id_reg   <= res_id_next;
        res_stat_reg <= res_stat_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
        out_stat_reg <= out_stat_next;
    end

endmodule
